### design/psched_pkg.sv
// shared types and constants for the priority task scheduler
package psched_pkg;

  localparam int MaxTasks = 16;
  localparam int SlotW    = $clog2(MaxTasks);
  localparam int CountW   = $clog2(MaxTasks + 1);

  localparam logic [2:0] CMD_CREATE = 3'd0;
  localparam logic [2:0] CMD_DELAY  = 3'd1;
  localparam logic [2:0] CMD_TICK   = 3'd2;
  localparam logic [2:0] CMD_START  = 3'd3;
  localparam logic [2:0] CMD_ENTER  = 3'd4;
  localparam logic [2:0] CMD_EXIT   = 3'd5;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NO_TASK   = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  priority_req;
    logic [15:0] delay_ticks;
  } in_word_t;

  typedef struct packed {
    logic [3:0] running_slot;
    logic       running_valid;
    logic [7:0] running_priority;
    logic       switched;
    status_t    status;
  } out_word_t;

endpackage

### design/priority_task_scheduler_top.sv
// priority task scheduler: slot table, interrupt depth and one-slot-per-cycle scan sequencer
//
// Each input word is one kernel event (create, delay, tick, start, interrupt enter,
// interrupt exit) and gives exactly one result word with the running task, a switch
// flag and a status. Task priorities and delay counters live in two slot memories with
// one read port each; a small sequencer walks the created slots one per cycle through a
// single comparator (scheduling) or a single decrementer (tick). An event that walks
// the table (tick, start, a delay that blocks the running task, create after start, the
// interrupt exit that reaches depth zero) scans all created slots before the next word
// is accepted; every other event goes from accept straight to its result. A result
// that is still stalled at the output holds the next one back by the length of the
// stall. The scan length is set by the one memory read port scanned a slot per cycle.
// A finished result sits in the output register, so the next word is taken while it
// waits. No clearing pass after reset is needed.
module priority_task_scheduler_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  psched_pkg::in_word_t  in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output psched_pkg::out_word_t out_word
);
  import psched_pkg::*;

  // sequencer and kernel state
  state_t              state;
  logic                is_tick;    // scan decrements counters instead of picking a task
  logic                do_sched;   // scheduling decision applies at the end of the event
  status_t             res_status;
  logic [CountW-1:0]   task_count;
  logic [SlotW-1:0]    current_slot;
  logic                current_valid;
  logic [7:0]          cur_prio;
  logic                kernel_started;
  logic [7:0]          isr_depth;
  logic [MaxTasks-1:0] blocked;

  // scan pipeline: issue address, then compare in the cycle after
  logic [CountW-1:0]   scan_idx;
  logic                pipe_vld;
  logic [SlotW-1:0]    pipe_idx;
  logic                found;
  logic [SlotW-1:0]    best_slot;
  logic [7:0]          best_prio;

  // slot memories
  logic [7:0]          prio_mem  [MaxTasks];
  logic [15:0]         delay_mem [MaxTasks];
  logic [7:0]          rd_prio;
  logic [15:0]         rd_delay;

  logic                accept;
  logic                issue;
  logic                tick_upd;
  logic [15:0]         tick_new;
  logic                prio_we;
  logic                dly_accept;
  logic                delay_we;
  logic [SlotW-1:0]    delay_addr;
  logic [15:0]         delay_data;
  logic                better;
  logic                sw_now;
  logic                out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign issue    = (state == S_SCAN) && (scan_idx < task_count);
  assign out_free = !out_valid || !out_stall;

  // tick: blocked slot counts down, a zero counter readies it at once
  assign tick_new = (rd_delay != 16'd0) ? (rd_delay - 16'd1) : 16'd0;
  assign tick_upd = (state == S_SCAN) && is_tick && pipe_vld && blocked[pipe_idx];

  // create writes the new slot's priority at accept time
  assign prio_we = accept && (in_word.cmd == CMD_CREATE) && (task_count != CountW'(MaxTasks));

  // delay writes the running slot's counter, tick writes back the decremented one
  assign dly_accept = accept && (in_word.cmd == CMD_DELAY) && (in_word.delay_ticks != 16'd0)
                      && current_valid;

  always_comb begin
    delay_we   = 1'b0;
    delay_addr = pipe_idx;
    delay_data = tick_new;
    if (dly_accept) begin
      delay_we   = 1'b1;
      delay_addr = current_slot;
      delay_data = in_word.delay_ticks;
    end else if (tick_upd) begin
      delay_we = 1'b1;
    end
  end

  // shared comparator: lower priority number wins, ties keep the earlier slot
  assign better = pipe_vld && !blocked[pipe_idx] && (!found || (rd_prio < best_prio));
  assign sw_now = do_sched && found && !(current_valid && (current_slot == best_slot));

  always_ff @(posedge clk) begin
    if (prio_we) begin
      prio_mem[task_count[SlotW-1:0]] <= in_word.priority_req;
    end
    rd_prio <= prio_mem[scan_idx[SlotW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (delay_we) begin
      delay_mem[delay_addr] <= delay_data;
    end
    rd_delay <= delay_mem[scan_idx[SlotW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      is_tick        <= 1'b0;
      do_sched       <= 1'b0;
      res_status     <= ST_OK;
      task_count     <= '0;
      current_slot   <= '0;
      current_valid  <= 1'b0;
      cur_prio       <= 8'd0;
      kernel_started <= 1'b0;
      isr_depth      <= 8'd0;
      blocked        <= '0;
      scan_idx       <= '0;
      pipe_vld       <= 1'b0;
      pipe_idx       <= '0;
      found          <= 1'b0;
      best_slot      <= '0;
      best_prio      <= 8'd0;
      out_valid      <= 1'b0;
    end else begin
      // result register: load a finished word, drop it once taken
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_status <= ST_OK;
            scan_idx   <= '0;
            pipe_vld   <= 1'b0;
            found      <= 1'b0;
            do_sched   <= 1'b0;
            is_tick    <= 1'b0;
            state      <= S_DONE;
            case (in_word.cmd)
              CMD_CREATE: begin
                if (task_count == CountW'(MaxTasks)) begin
                  res_status <= ST_FULL;
                end else begin
                  blocked[task_count[SlotW-1:0]] <= 1'b0;
                  task_count <= task_count + CountW'(1);
                  if (kernel_started) begin
                    do_sched <= 1'b1;
                    state    <= S_SCAN;
                  end
                end
              end
              CMD_DELAY: begin
                if (in_word.delay_ticks != 16'd0) begin
                  if (!current_valid) begin
                    res_status <= ST_NO_TASK;
                  end else begin
                    blocked[current_slot] <= 1'b1;
                    do_sched <= 1'b1;
                    state    <= S_SCAN;
                  end
                end
              end
              CMD_TICK: begin
                is_tick <= 1'b1;
                state   <= S_SCAN;
              end
              CMD_START: begin
                kernel_started <= 1'b1;
                do_sched       <= 1'b1;
                state          <= S_SCAN;
              end
              CMD_ENTER: begin
                if (isr_depth != 8'hFF) begin
                  isr_depth <= isr_depth + 8'd1;
                end
              end
              CMD_EXIT: begin
                if (isr_depth == 8'd0) begin
                  res_status <= ST_UNDERFLOW;
                end else begin
                  isr_depth <= isr_depth - 8'd1;
                  if (isr_depth == 8'd1) begin
                    do_sched <= 1'b1;
                    state    <= S_SCAN;
                  end
                end
              end
              default: begin
                // unused command codes: nothing changes
              end
            endcase
          end
        end
        S_SCAN: begin
          pipe_vld <= issue;
          pipe_idx <= scan_idx[SlotW-1:0];
          if (issue) begin
            scan_idx <= scan_idx + CountW'(1);
          end
          if (tick_upd && (tick_new == 16'd0)) begin
            blocked[pipe_idx] <= 1'b0;
          end
          if (!is_tick && better) begin
            found     <= 1'b1;
            best_slot <= pipe_idx;
            best_prio <= rd_prio;
          end
          if (!issue && !pipe_vld) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_word.switched <= sw_now;
            out_word.status   <= res_status;
            if (sw_now) begin
              current_slot  <= best_slot;
              current_valid <= 1'b1;
              cur_prio      <= best_prio;
              out_word.running_slot     <= 4'(best_slot);
              out_word.running_valid    <= 1'b1;
              out_word.running_priority <= best_prio;
            end else begin
              out_word.running_slot     <= 4'(current_slot);
              out_word.running_valid    <= current_valid;
              out_word.running_priority <= current_valid ? cur_prio : 8'd0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### test/tb_priority_task_scheduler_top.sv
// testbench for the priority task scheduler: directed and random kernel events checked against a predictor
`timescale 1ns / 1ps

module tb_priority_task_scheduler_top;
  import psched_pkg::*;

  // command codes the block treats as no-ops
  localparam logic [2:0] CMD_RSVD_A = 3'd6;
  localparam logic [2:0] CMD_RSVD_B = 3'd7;

  localparam int RandomEvents = 400;
  // slowest word: the longest send gap, a full table scan and the longest result stall,
  // about 450 words in all; the limit is many times that
  localparam longint CycleLimit = 300000;
  localparam int DrainLimit = 2000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  priority_task_scheduler_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // predicted kernel state: slot table, running task, nesting depth
  logic [7:0]       k_prio    [MaxTasks];
  bit               k_blocked [MaxTasks];
  logic [15:0]      k_wait    [MaxTasks];
  int               k_count;
  logic [SlotW-1:0] k_run;
  bit               k_run_valid;
  bit               k_started;
  int               k_depth;

  // dispatch results still owed by the block, oldest first
  out_word_t dispatch_q[$];
  out_word_t want_word;

  int     errors;
  int     words_sent;
  int     results_seen;
  int     switches_seen;
  int     status_seen[4];
  longint cycle_count = 0;
  bit     tx_quiet;
  bit     rx_quiet;
  int     stall_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // hard stop in case the block hangs
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("%0t: timeout after %0d cycles, %0d results still owed", $time, cycle_count,
             dispatch_q.size());
    $display("Some tests failed");
    $finish;
  end

  // pick the ready slot with the lowest priority number, earliest slot on a tie;
  // returns 1 when the running task changes
  function automatic bit pick_ready_task();
    int best;
    bit found;
    best = 0;
    found = 1'b0;
    for (int i = 0; i < k_count; i++) begin
      if (!k_blocked[i] && (!found || k_prio[i] < k_prio[best])) begin
        best = i;
        found = 1'b1;
      end
    end
    if (!found) return 1'b0;
    if (k_run_valid && k_run == SlotW'(best)) return 1'b0;
    k_run = SlotW'(best);
    k_run_valid = 1'b1;
    return 1'b1;
  endfunction

  // apply one kernel event to the predicted state and build the dispatch word
  function automatic out_word_t kernel_event(in_word_t w);
    out_word_t r;
    bit        sw;
    status_t   st;
    sw = 1'b0;
    st = ST_OK;
    case (w.cmd)
      CMD_CREATE: begin
        if (k_count >= MaxTasks) begin
          st = ST_FULL;
        end else begin
          k_prio[k_count] = w.priority_req;
          k_blocked[k_count] = 1'b0;
          k_wait[k_count] = '0;
          k_count++;
          if (k_started) sw = pick_ready_task();
        end
      end
      CMD_DELAY: begin
        // zero ticks is a no-op even with no task running
        if (w.delay_ticks != 0) begin
          if (!k_run_valid) begin
            st = ST_NO_TASK;
          end else begin
            k_wait[k_run] = w.delay_ticks;
            k_blocked[k_run] = 1'b1;
            sw = pick_ready_task();
          end
        end
      end
      CMD_TICK: begin
        // ticks only count down, never reschedule
        for (int i = 0; i < k_count; i++) begin
          if (k_blocked[i]) begin
            if (k_wait[i] != 0) k_wait[i] = k_wait[i] - 16'd1;
            if (k_wait[i] == 0) k_blocked[i] = 1'b0;
          end
        end
      end
      CMD_START: begin
        k_started = 1'b1;
        sw = pick_ready_task();
      end
      CMD_ENTER: begin
        if (k_depth < 255) k_depth++;
      end
      CMD_EXIT: begin
        if (k_depth == 0) begin
          st = ST_UNDERFLOW;
        end else begin
          k_depth--;
          if (k_depth == 0) sw = pick_ready_task();
        end
      end
      default: ;
    endcase
    r.running_slot     = k_run_valid ? k_run : '0;
    r.running_valid    = k_run_valid;
    r.running_priority = k_run_valid ? k_prio[k_run] : '0;
    r.switched         = sw;
    r.status           = st;
    return r;
  endfunction

  // send one word; valid stays up across back-to-back words so it is never
  // lowered and raised in the same step
  task automatic post_event(logic [2:0] cmd, logic [7:0] prio, logic [15:0] ticks);
    in_word_t w;
    int       gap;
    w.cmd = cmd;
    w.priority_req = prio;
    w.delay_ticks = ticks;
    if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    dispatch_q.push_back(kernel_event(w));
    words_sent++;
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // result side: check every accepted word, then stall for a random stretch
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (dispatch_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, expected none, actual %p", $time,
                   out_word);
        end else begin
          want_word = dispatch_q.pop_front();
          check_field("running_slot", 8'(want_word.running_slot), 8'(out_word.running_slot));
          check_field("running_valid", 8'(want_word.running_valid),
                      8'(out_word.running_valid));
          check_field("running_priority", want_word.running_priority,
                      out_word.running_priority);
          check_field("switched", 8'(want_word.switched), 8'(out_word.switched));
          check_field("status", 8'(want_word.status), 8'(out_word.status));
          results_seen++;
          if (want_word.switched) switches_seen++;
          status_seen[want_word.status]++;
        end
        if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
        stall_left = rx_quiet ? 0 : $urandom_range(0, 7);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // empty table: underflow, delay with nothing running, zero delay, no-op codes
  task automatic test_idle_kernel();
    post_event(CMD_EXIT, 8'($urandom), 16'($urandom));
    post_event(CMD_DELAY, 8'($urandom), 16'd5);
    post_event(CMD_DELAY, 8'($urandom), 16'd0);
    post_event(CMD_TICK, 8'($urandom), 16'($urandom));
    post_event(CMD_RSVD_A, 8'hff, 16'hffff);
    post_event(CMD_RSVD_B, 8'h00, 16'h0000);
    // exit back to depth zero with no task to pick
    post_event(CMD_ENTER, 8'($urandom), 16'($urandom));
    post_event(CMD_EXIT, 8'($urandom), 16'($urandom));
  endtask

  // scheduling before and right after start: exit to zero dispatches, delay
  // blocks before start, blocked running task kept, ties, creates after start
  task automatic test_before_start();
    post_event(CMD_CREATE, 8'd255, 16'($urandom));     // slot 0
    post_event(CMD_CREATE, 8'h80, 16'($urandom));      // slot 1
    post_event(CMD_ENTER, 8'($urandom), 16'($urandom));
    post_event(CMD_EXIT, 8'($urandom), 16'($urandom)); // picks slot 1
    post_event(CMD_DELAY, 8'($urandom), 16'd2);        // slot 1 blocks, slot 0 runs
    post_event(CMD_DELAY, 8'($urandom), 16'd1);        // nothing ready, slot 0 kept
    post_event(CMD_START, 8'($urandom), 16'($urandom));
    post_event(CMD_TICK, 8'($urandom), 16'($urandom)); // slot 0 ready, no reschedule
    post_event(CMD_CREATE, 8'd0, 16'($urandom));       // slot 2 preempts
    post_event(CMD_CREATE, 8'd0, 16'($urandom));       // slot 3 ties, slot 2 stays
    post_event(CMD_TICK, 8'($urandom), 16'($urandom));
    post_event(CMD_DELAY, 8'($urandom), 16'hffff);     // slot 2 out for good
    post_event(CMD_DELAY, 8'($urandom), 16'd0);
    post_event(CMD_START, 8'($urandom), 16'($urandom));
  endtask

  // nesting a few levels deep unwinds to zero, then underflows
  task automatic test_irq_nesting();
    repeat (3) post_event(CMD_ENTER, 8'($urandom), 16'($urandom));
    repeat (3) post_event(CMD_EXIT, 8'($urandom), 16'($urandom));
    post_event(CMD_EXIT, 8'($urandom), 16'($urandom));
  endtask

  // mostly short delays and ticks so tasks block and wake often; creates fill
  // the table along the way, long delays and stray exits are the noise
  task automatic test_random_events();
    int          pick;
    int          sel;
    logic [2:0]  cmd;
    logic [7:0]  prio;
    logic [15:0] ticks;
    for (int n = 0; n < RandomEvents; n++) begin
      pick = $urandom_range(0, 99);
      // narrow priority band now and then to force ties
      prio = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
      ticks = 16'($urandom);
      if (pick < 12) begin
        cmd = CMD_CREATE;
      end else if (pick < 32) begin
        cmd = CMD_DELAY;
        sel = $urandom_range(0, 99);
        if (sel < 10) ticks = '0;
        else if (sel < 75) ticks = 16'($urandom_range(1, 6));
        else if (sel < 97) ticks = 16'($urandom_range(7, 40));
      end else if (pick < 62) begin
        cmd = CMD_TICK;
      end else if (pick < 72) begin
        cmd = CMD_ENTER;
      end else if (pick < 85) begin
        cmd = CMD_EXIT;
      end else if (pick < 90) begin
        cmd = CMD_START;
      end else if (pick < 94) begin
        cmd = $urandom_range(0, 1) ? CMD_RSVD_A : CMD_RSVD_B;
      end else begin
        cmd = CMD_TICK;
      end
      post_event(cmd, prio, ticks);
    end
  endtask

  // fill whatever slots are left, then overfill
  task automatic test_table_full();
    while (k_count < MaxTasks) post_event(CMD_CREATE, 8'($urandom), 16'($urandom));
    repeat (2) post_event(CMD_CREATE, 8'($urandom), 16'($urandom));
  endtask

  initial begin
    int drain;
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    errors = 0;
    words_sent = 0;
    results_seen = 0;
    switches_seen = 0;
    tx_quiet = 1'b0;
    for (int s = 0; s < 4; s++) status_seen[s] = 0;
    // predictor starts from the reset state
    for (int i = 0; i < MaxTasks; i++) begin
      k_prio[i] = '0;
      k_blocked[i] = 1'b0;
      k_wait[i] = '0;
    end
    k_count = 0;
    k_run = '0;
    k_run_valid = 1'b0;
    k_started = 1'b0;
    k_depth = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_idle_kernel();
    test_before_start();
    test_irq_nesting();
    test_random_events();
    test_table_full();
    in_valid <= 1'b0;

    // let the last results drain, then give the block a full scan's worth of slack
    drain = 0;
    while (dispatch_q.size() != 0 && drain < DrainLimit) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);
    if (dispatch_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived, expected 0 owed, actual %0d", $time,
               dispatch_q.size(), dispatch_q.size());
    end

    $display("run: %0d kernel words sent, %0d dispatch words checked, %0d task switches",
             words_sent, results_seen, switches_seen);
    $display("statuses: ok %0d, table full %0d, delay without task %0d, depth underflow %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NO_TASK],
             status_seen[ST_UNDERFLOW]);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
